[design/bale_pkg.sv]
package bale_pkg;

    localparam int CAPACITY = 64;
    localparam int AW       = $clog2(CAPACITY);
    localparam int LW       = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 7;
    localparam int DATA_W   = 32;

    localparam logic [DATA_W-1:0] MARKER_RESET = 32'hFFFF_D8F1;

    localparam logic [2:0] FN_CLEAR       = 3'd0;
    localparam logic [2:0] FN_GET         = 3'd1;
    localparam logic [2:0] FN_SET         = 3'd2;
    localparam logic [2:0] FN_INSERT_AT   = 3'd3;
    localparam logic [2:0] FN_INSERT_LAST = 3'd4;
    localparam logic [2:0] FN_DELETE_AT   = 3'd5;
    localparam logic [2:0] FN_DELETE_LAST = 3'd6;
    localparam logic [2:0] FN_SEARCH      = 3'd7;

    typedef struct packed {
        logic [2:0]              func;
        logic [IDX_W-1:0]        index;
        logic signed [DATA_W-1:0] value;
        logic                    check_only;
    } cmd_t;

    typedef struct packed {
        logic                     status;
        logic signed [DATA_W-1:0] read_value;
        logic                     found;
        logic                     index_valid;
        logic                     index_effective;
        logic [6:0]               list_length;
        logic                     list_empty;
    } result_t;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_GET,
        ST_MOVE,
        ST_FINAL,
        ST_SWEEP,
        ST_RESULT
    } state_t;

endpackage

[design/bounded_array_list_engine_core.sv]
// Channel   Ports                     Direction  Beat taken when
// ------    ------------------------  ---------  ---------------------------------
// command   start, busy, cmd          in         start && !busy at a rising edge
// result    done, result              out        done high (one cycle, no stall)
// config    cfg_we, cfg_wdata         in         cfg_we high at a rising edge
//
// Steps: scan entry 0 up to the first empty entry (the whole store when full), then
// decide and result; done and a low busy follow. When accepted, get adds a state that
// latches the read entry; set, insert-last and delete-last add a rescan; insert-at and
// delete-at add a shift of the moved entries, one final write and a rescan; clear adds
// a sweep and a rescan. Reset: sweep the reset marker into the store (busy high, config
// writes taken); the receiver has no way to stall the one-cycle result beat.
module bounded_array_list_engine_core
    import bale_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmd_t              cmd,
    output logic              done,
    output result_t           result,
    input  logic              cfg_we,
    input  logic [DATA_W-1:0] cfg_wdata
);

    // list store: one write port, one registered read port
    logic [DATA_W-1:0] mem [CAPACITY];
    logic [DATA_W-1:0] mem_rdata_reg;
    logic [AW-1:0]     mem_raddr;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [DATA_W-1:0] mem_wdata;

    state_t            state_reg, state_next;
    logic [LW-1:0]     ptr_reg, ptr_next;        // scan / sweep / shift source
    logic              pend_reg, pend_next;      // read in flight
    logic [AW-1:0]     pend_addr_reg, pend_addr_next;
    logic [LW-1:0]     cnt_reg, cnt_next;        // entries left to shift
    logic [LW-1:0]     len_reg, len_next;
    logic              found_reg, found_next;
    logic              post_reg, post_next;      // scan after the change
    logic              status_reg, status_next;
    logic [DATA_W-1:0] rd_reg, rd_next;
    cmd_t              cmd_reg, cmd_next;
    result_t           res_reg, res_next;
    logic              done_reg, done_next;
    logic [DATA_W-1:0] marker_reg;

    logic [IDX_W:0]    idx_w;
    logic [IDX_W:0]    len_w;
    logic [IDX_W:0]    cap_w;
    logic              idx_in_cap;
    logic              is_search;
    logic              is_check;
    logic [LW-1:0]     len_m1;

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = res_reg;

    assign idx_w      = {1'b0, cmd_reg.index};
    assign len_w      = (IDX_W + 1)'(len_reg);
    assign cap_w      = (IDX_W + 1)'(CAPACITY);
    assign idx_in_cap = idx_w < cap_w;
    assign is_search  = (cmd_reg.func == FN_SEARCH) && !cmd_reg.check_only;
    assign is_check   = (cmd_reg.func == FN_SEARCH) && cmd_reg.check_only;
    assign len_m1     = len_reg - LW'(1);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        mem_rdata_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARKER_RESET;
        end
        else if (cfg_we)
        begin
            marker_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
            post_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
            post_reg  <= post_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        cnt_reg       <= cnt_next;
        len_reg       <= len_next;
        found_reg     <= found_next;
        status_reg    <= status_next;
        rd_reg        <= rd_next;
        cmd_reg       <= cmd_next;
        res_reg       <= res_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        cnt_next       = cnt_reg;
        len_next       = len_reg;
        found_next     = found_reg;
        post_next      = post_reg;
        status_next    = status_reg;
        rd_next        = rd_reg;
        cmd_next       = cmd_reg;
        res_next       = res_reg;
        done_next      = 1'b0;
        mem_raddr      = ptr_reg[AW-1:0];
        mem_we         = 1'b0;
        mem_waddr      = ptr_reg[AW-1:0];
        mem_wdata      = marker_reg;

        case (state_reg)
            ST_INIT:
            begin
                // fill the store with the reset marker
                mem_we    = 1'b1;
                mem_wdata = MARKER_RESET;
                ptr_next  = ptr_reg + LW'(1);
                if (ptr_reg[AW-1:0] == AW'(CAPACITY - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    ptr_next    = '0;
                    pend_next   = 1'b0;
                    found_next  = 1'b0;
                    post_next   = 1'b0;
                    status_next = 1'b0;
                    rd_next     = '0;
                    state_next  = ST_SCAN;
                end
            end

            ST_SCAN:
            begin
                // issue one read a cycle, check the beat from the cycle before
                if (ptr_reg < LW'(CAPACITY))
                begin
                    pend_next      = 1'b1;
                    pend_addr_next = ptr_reg[AW-1:0];
                    ptr_next       = ptr_reg + LW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    if (mem_rdata_reg == marker_reg)
                    begin
                        len_next   = LW'(pend_addr_reg);
                        pend_next  = 1'b0;
                        state_next = post_reg ? ST_RESULT : ST_DECIDE;
                    end
                    else
                    begin
                        if (!post_reg && (mem_rdata_reg == cmd_reg.value))
                        begin
                            found_next = 1'b1;
                        end
                        if (pend_addr_reg == AW'(CAPACITY - 1))
                        begin
                            len_next   = LW'(CAPACITY);
                            pend_next  = 1'b0;
                            state_next = post_reg ? ST_RESULT : ST_DECIDE;
                        end
                    end
                end
            end

            ST_DECIDE:
            begin
                post_next  = 1'b1;
                ptr_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_RESULT;
                case (cmd_reg.func)
                    FN_CLEAR:
                    begin
                        state_next = ST_SWEEP;
                    end
                    FN_GET:
                    begin
                        mem_raddr = cmd_reg.index[AW-1:0];
                        if (idx_in_cap)
                        begin
                            state_next = ST_GET;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    FN_SET:
                    begin
                        if (idx_in_cap)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = cmd_reg.index[AW-1:0];
                            mem_wdata  = cmd_reg.value;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    FN_INSERT_AT:
                    begin
                        if ((len_w < cap_w) && (idx_w <= len_w))
                        begin
                            ptr_next   = len_m1;
                            cnt_next   = len_reg - LW'(cmd_reg.index);
                            state_next = ST_MOVE;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    FN_INSERT_LAST:
                    begin
                        if (len_w < cap_w)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = len_reg[AW-1:0];
                            mem_wdata  = cmd_reg.value;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    FN_DELETE_AT:
                    begin
                        if ((len_reg != '0) && (idx_w < len_w))
                        begin
                            ptr_next   = LW'(cmd_reg.index) + LW'(1);
                            cnt_next   = len_m1 - LW'(cmd_reg.index);
                            state_next = ST_MOVE;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    FN_DELETE_LAST:
                    begin
                        if (len_reg != '0)
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = len_m1[AW-1:0];
                            mem_wdata  = marker_reg;
                            state_next = ST_SCAN;
                        end
                        else
                        begin
                            status_next = 1'b1;
                        end
                    end
                    default:
                    begin
                        state_next = ST_RESULT;
                    end
                endcase
            end

            ST_GET:
            begin
                rd_next    = mem_rdata_reg;
                state_next = ST_RESULT;
            end

            ST_MOVE:
            begin
                // read one entry a cycle, write it one place over once the registered read returns
                if (cnt_reg != '0)
                begin
                    pend_next = 1'b1;
                    cnt_next  = cnt_reg - LW'(1);
                    if (cmd_reg.func == FN_INSERT_AT)
                    begin
                        pend_addr_next = ptr_reg[AW-1:0] + AW'(1);
                        ptr_next       = ptr_reg - LW'(1);
                    end
                    else
                    begin
                        pend_addr_next = ptr_reg[AW-1:0] - AW'(1);
                        ptr_next       = ptr_reg + LW'(1);
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg;
                    mem_wdata = mem_rdata_reg;
                end
                if ((cnt_reg == '0) && !pend_reg)
                begin
                    state_next = ST_FINAL;
                end
            end

            ST_FINAL:
            begin
                mem_we = 1'b1;
                if (cmd_reg.func == FN_INSERT_AT)
                begin
                    mem_waddr = cmd_reg.index[AW-1:0];
                    mem_wdata = cmd_reg.value;
                end
                else
                begin
                    mem_waddr = len_m1[AW-1:0];
                    mem_wdata = marker_reg;
                end
                ptr_next   = '0;
                pend_next  = 1'b0;
                state_next = ST_SCAN;
            end

            ST_SWEEP:
            begin
                mem_we    = 1'b1;
                mem_wdata = marker_reg;
                ptr_next  = ptr_reg + LW'(1);
                if (ptr_reg[AW-1:0] == AW'(CAPACITY - 1))
                begin
                    ptr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = ST_SCAN;
                end
            end

            ST_RESULT:
            begin
                res_next.status          = status_reg;
                res_next.read_value      = rd_reg;
                res_next.found           = is_search && found_reg;
                res_next.index_valid     = is_check && idx_in_cap;
                res_next.index_effective = is_check && (idx_w < len_w);
                res_next.list_length     = 7'(len_reg);
                res_next.list_empty      = (len_reg == '0);
                done_next                = 1'b1;
                state_next               = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[dv/tb_bounded_array_list_engine_core.sv]
`timescale 1ns / 1ps

module tb_bounded_array_list_engine_core
    import bale_pkg::*;
();

    // Clock, reset and run-length knobs
    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 4;
    // The limit outlasts the slowest command plus the longest sender gap.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 3 * CAPACITY + 16;
    localparam int PRINT_CAP      = 40;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    cmd_t              cmd       = '0;
    logic              done;
    result_t           result;
    logic              cfg_we    = 1'b0;
    logic [DATA_W-1:0] cfg_wdata = '0;

    bounded_array_list_engine_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #CLK_HALF clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the list and its marker register. The monitor below
    // updates both on the edge that takes each command or config beat.
    // ------------------------------------------------------------------
    logic [DATA_W-1:0] store [CAPACITY];
    logic [DATA_W-1:0] marker_q;
    result_t           pending_results [$];
    result_t           mon_expected;

    int error_count     = 0;
    int cmds_accepted   = 0;
    int results_checked = 0;
    int refused_count   = 0;
    int full_count      = 0;
    int marker_writes   = 0;
    int quiet_cycles    = 0;
    int sender_idle_pct = 0;
    bit grow_mode       = 1'b1;

    // Length is the position of the first entry holding the marker bits.
    function automatic int list_len();
        int n;
        n = 0;
        while (n < CAPACITY && store[n] != marker_q)
            n++;
        return n;
    endfunction

    // Apply one command to the shadow list and build the result it must produce.
    function automatic result_t apply_list_op(cmd_t c);
        result_t r;
        int      len;
        int      idx;
        int      k;
        r   = '0;
        len = list_len();
        idx = c.index;
        case (c.func)
            FN_CLEAR:
            begin
                for (k = 0; k < CAPACITY; k++)
                    store[k] = marker_q;
            end
            FN_GET:
            begin
                if (idx < CAPACITY)
                    r.read_value = store[idx];
                else
                    r.status = 1'b1;
            end
            FN_SET:
            begin
                if (idx < CAPACITY)
                    store[idx] = c.value;
                else
                    r.status = 1'b1;
            end
            FN_INSERT_AT:
            begin
                if (len < CAPACITY && idx <= len)
                begin
                    // Shift the tail up by one, then drop the new word in.
                    for (k = len; k > idx; k--)
                        store[k] = store[k-1];
                    store[idx] = c.value;
                end
                else
                    r.status = 1'b1;
            end
            FN_INSERT_LAST:
            begin
                if (len < CAPACITY)
                    store[len] = c.value;
                else
                    r.status = 1'b1;
            end
            FN_DELETE_AT:
            begin
                if (len > 0 && idx < len)
                begin
                    // Shift the tail down and empty the old last entry.
                    for (k = idx; k + 1 < len; k++)
                        store[k] = store[k+1];
                    store[len-1] = marker_q;
                end
                else
                    r.status = 1'b1;
            end
            FN_DELETE_LAST:
            begin
                if (len > 0)
                    store[len-1] = marker_q;
                else
                    r.status = 1'b1;
            end
            default:
            begin
                if (c.check_only)
                begin
                    r.index_valid     = (idx < CAPACITY);
                    r.index_effective = (idx < len);
                end
                else
                begin
                    // Only entries below the length can match.
                    for (k = 0; k < len; k++)
                        if (store[k] == c.value)
                            r.found = 1'b1;
                end
            end
        endcase
        len           = list_len();
        r.list_length = len[6:0];
        r.list_empty  = (store[0] == marker_q);
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                   input logic [31:0] got_v);
        error_count++;
        if (error_count <= PRINT_CAP)
            $display("[%0t] mismatch on result %0d, %s: expected %h, got %h",
                     $time, results_checked, what, exp_v, got_v);
    endtask

    task automatic compare_result(input result_t exp_r, input result_t got_r);
        if (got_r.status !== exp_r.status)
            report_mismatch("status", 32'(exp_r.status), 32'(got_r.status));
        if (got_r.read_value !== exp_r.read_value)
            report_mismatch("read_value", exp_r.read_value, got_r.read_value);
        if (got_r.found !== exp_r.found)
            report_mismatch("found", 32'(exp_r.found), 32'(got_r.found));
        if (got_r.index_valid !== exp_r.index_valid)
            report_mismatch("index_valid", 32'(exp_r.index_valid),
                            32'(got_r.index_valid));
        if (got_r.index_effective !== exp_r.index_effective)
            report_mismatch("index_effective", 32'(exp_r.index_effective),
                            32'(got_r.index_effective));
        if (got_r.list_length !== exp_r.list_length)
            report_mismatch("list_length", 32'(exp_r.list_length),
                            32'(got_r.list_length));
        if (got_r.list_empty !== exp_r.list_empty)
            report_mismatch("list_empty", 32'(exp_r.list_empty), 32'(got_r.list_empty));
    endtask

    // ------------------------------------------------------------------
    // Monitor: sample every channel at the rising edge. Check the result
    // beat first, then predict the command beat, then take the config beat,
    // so a result and the next command on one edge never get mixed up.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                    report_mismatch("result beat with nothing pending", '0,
                                    result.read_value);
                else
                begin
                    mon_expected = pending_results.pop_front();
                    compare_result(mon_expected, result);
                    results_checked++;
                end
            end
            if (start && !busy)
            begin
                mon_expected = apply_list_op(cmd);
                pending_results.push_back(mon_expected);
                cmds_accepted++;
                if (mon_expected.status)
                    refused_count++;
                if (mon_expected.list_length == CAPACITY)
                    full_count++;
            end
            if (cfg_we)
                marker_q = cfg_wdata;
        end
    end

    // Watchdog: end the run when no beat of any kind moves for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] watchdog: no beat for %0d cycles, %0d results pending",
                     $time, WATCHDOG_LIMIT, pending_results.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drive helpers. All of them start and end on a rising edge.
    // ------------------------------------------------------------------
    function automatic cmd_t make_cmd(input logic [2:0] fn, input int idx,
                                      input logic [31:0] val, input logic chk);
        cmd_t c;
        c.func       = fn;
        c.index      = idx[IDX_W-1:0];
        c.value      = val;
        c.check_only = chk;
        return c;
    endfunction

    // Raise start with the beat and hold it until the edge that takes it.
    task automatic send_cmd(input cmd_t c);
        start <= 1'b1;
        cmd   <= c;
        do
            @(posedge clk);
        while (busy);
    endtask

    // Idle the sender between beats; every 40 items open with a gap-free stretch.
    task automatic sender_gap(input int item);
        int gap;
        if ((item % 40) >= 10 && $urandom_range(0, 99) < sender_idle_pct)
        begin
            if ($urandom_range(0, 7) == 0)
                gap = $urandom_range(20, 150);
            else
                gap = $urandom_range(1, 10);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop start, let every pending result come back, then wait for busy to fall.
    task automatic wait_idle();
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_marker(input logic [DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        marker_writes++;
    endtask

    // Build one random command, biased by the shadow length so the list
    // swings between empty and full; one item in ten is pure noise.
    function automatic cmd_t random_cmd();
        cmd_t        c;
        int          len;
        int          pick;
        int          idx;
        logic [31:0] val;
        len  = list_len();
        pick = $urandom_range(0, 99);

        if (len == CAPACITY && $urandom_range(0, 3) == 0)
            grow_mode = 1'b0;
        else if (len == 0)
            grow_mode = 1'b1;

        case ($urandom_range(0, 19))
            0:       val = marker_q;
            1:       val = 32'h8000_0000;
            2:       val = 32'h7FFF_FFFF;
            3, 4, 5: val = store[$urandom_range(0, (len > 0) ? len - 1 : 0)];
            default: val = $urandom;
        endcase

        if ($urandom_range(0, 99) < 60)
            idx = $urandom_range(0, len);
        else if ($urandom_range(0, 99) < 60)
            idx = $urandom_range(0, CAPACITY - 1);
        else
            idx = $urandom_range(0, 127);

        c = make_cmd(FN_SEARCH, idx, val, 1'($urandom_range(0, 1)));
        if (pick < 10)
            c = make_cmd(3'($urandom_range(0, 7)), $urandom_range(0, 127), $urandom,
                         1'($urandom_range(0, 1)));
        else if (pick < 12)
            c.func = FN_CLEAR;
        else if (pick < 22)
            c.func = FN_GET;
        else if (pick < 30)
            c.func = FN_SET;
        else if (pick < 70)
        begin
            // Grow phase favors inserts, shrink phase favors deletes.
            if (grow_mode)
                c.func = (pick < 50) ? FN_INSERT_LAST : (pick < 63) ? FN_INSERT_AT
                                                                    : FN_DELETE_AT;
            else
                c.func = (pick < 50) ? FN_DELETE_LAST : (pick < 63) ? FN_DELETE_AT
                                                                    : FN_INSERT_AT;
        end
        // Anything left stays a search or an index check.
        return c;
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Boundaries on the reset marker: empty list, out-of-range index,
    // refusals, set past the length, marker written as data, search that
    // must skip entries past the length.
    task automatic test_directed_edges();
        logic [31:0] mk;
        mk = MARKER_RESET;
        wait_idle();
        send_cmd(make_cmd(FN_SEARCH, 0, mk, 1'b0));          // marker not found when empty
        send_cmd(make_cmd(FN_GET, 0, 32'h0, 1'b0));
        send_cmd(make_cmd(FN_GET, 127, 32'h0, 1'b0));        // past capacity
        send_cmd(make_cmd(FN_SET, 127, 32'hFFFF_FFFF, 1'b1));
        send_cmd(make_cmd(FN_DELETE_LAST, 0, 32'h0, 1'b0));  // empty list
        send_cmd(make_cmd(FN_DELETE_AT, 0, 32'h0, 1'b0));
        send_cmd(make_cmd(FN_INSERT_AT, 1, 32'h1, 1'b0));    // above the length
        send_cmd(make_cmd(FN_INSERT_LAST, 0, 32'h7FFF_FFFF, 1'b0));
        send_cmd(make_cmd(FN_INSERT_AT, 0, 32'h8000_0000, 1'b0));
        send_cmd(make_cmd(FN_INSERT_AT, 2, 32'h1, 1'b0));    // index equal to length
        send_cmd(make_cmd(FN_SEARCH, 2, 32'h0, 1'b1));       // valid and effective
        send_cmd(make_cmd(FN_SEARCH, 3, 32'h0, 1'b1));       // valid only
        send_cmd(make_cmd(FN_SEARCH, 127, 32'h0, 1'b1));     // neither
        send_cmd(make_cmd(FN_SEARCH, 0, 32'h8000_0000, 1'b0));
        send_cmd(make_cmd(FN_SET, 5, 32'h7, 1'b0));          // past length, length holds
        send_cmd(make_cmd(FN_SET, 3, 32'h9, 1'b0));
        send_cmd(make_cmd(FN_SET, 4, 32'hB, 1'b0));          // bridges the gap
        send_cmd(make_cmd(FN_INSERT_LAST, 0, mk, 1'b0));     // marker as data
        send_cmd(make_cmd(FN_SET, 1, mk, 1'b0));             // shortens to one
        send_cmd(make_cmd(FN_DELETE_AT, 0, 32'h0, 1'b0));
        send_cmd(make_cmd(FN_SEARCH, 0, 32'h1, 1'b0));       // stale entry past length
        send_cmd(make_cmd(FN_INSERT_LAST, 127, 32'h5, 1'b1));
        send_cmd(make_cmd(FN_DELETE_LAST, 127, 32'hFFFF_FFFF, 1'b1));
        send_cmd(make_cmd(FN_CLEAR, 127, 32'hFFFF_FFFF, 1'b1));
    endtask

    // Move the marker off the stored bits so every entry counts: full list.
    task automatic test_marker_full_list();
        wait_idle();
        write_marker(32'h0);
        send_cmd(make_cmd(FN_INSERT_LAST, 0, 32'h3, 1'b0));  // full, refused
        send_cmd(make_cmd(FN_INSERT_AT, 0, 32'h3, 1'b0));    // full, refused
        send_cmd(make_cmd(FN_SEARCH, 63, 32'h0, 1'b1));
        send_cmd(make_cmd(FN_SEARCH, 0, MARKER_RESET, 1'b0));
        send_cmd(make_cmd(FN_DELETE_AT, 63, 32'h0, 1'b0));
        send_cmd(make_cmd(FN_DELETE_LAST, 0, 32'h0, 1'b0));
        send_cmd(make_cmd(FN_INSERT_AT, 10, 32'hFFFF_FFFF, 1'b0));
        send_cmd(make_cmd(FN_INSERT_LAST, 0, 32'h1234_5678, 1'b0));
        send_cmd(make_cmd(FN_CLEAR, 0, 32'h0, 1'b0));
    endtask

    // Random list traffic under one marker and one sender idle level.
    task automatic test_random_ops(input logic [DATA_W-1:0] mk, input int idle_pct,
                                   input int n_items, input bit clear_first);
        int i;
        wait_idle();
        write_marker(mk);
        sender_idle_pct = idle_pct;
        if (clear_first)
            send_cmd(make_cmd(FN_CLEAR, 0, 32'h0, 1'b0));
        for (i = 0; i < n_items; i++)
        begin
            send_cmd(random_cmd());
            sender_gap(i);
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int k;
        marker_q = MARKER_RESET;
        for (k = 0; k < CAPACITY; k++)
            store[k] = MARKER_RESET;

        // Hold reset, then release it on an edge; the clearing sweep shows as busy.
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_marker_full_list();
        test_random_ops(32'h8000_0000, 0, 180, 1'b1);
        test_random_ops(32'h7FFF_FFFF, 65, 180, 1'b0);
        test_random_ops($urandom, 11, 180, 1'b1);
        test_random_ops(32'hFFFF_FFFF, 65, 110, 1'b0);
        test_random_ops(MARKER_RESET, 0, 100, 1'b1);

        // Drain: let the last result land, then watch for stray beats.
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never returned", pending_results.size(), '0);

        $display("Covered %0d commands (%0d refused, %0d leaving the list full), %0d results",
                 cmds_accepted, refused_count, full_count, results_checked);
        $display("checked under %0d marker settings incl. both signed extremes, 0 and -1",
                 marker_writes);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
